// File: hdl/srsbr_pkg.sv
// ----------------------------------------------------------------------------
// srsbr_pkg
// Shared widths, constants and control types of the replacement engine.
// ----------------------------------------------------------------------------
package srsbr_pkg;

   localparam int NUM_SETS_DEF = 2048;
   localparam int NUM_WAYS_DEF = 16;

   localparam int SET_IN_W  = 11;
   localparam int WAY_IN_W  = 4;
   localparam int ADDR_W    = 64;
   localparam int PC_W      = 64;
   localparam int RRV_W     = 2;
   localparam int SIG_W     = 6;
   localparam int SCNT_W    = 2;
   localparam int STREAM_W  = 3;

   localparam logic             CMD_VICTIM   = 1'b0;
   localparam logic             CMD_UPDATE   = 1'b1;

   localparam logic [RRV_W-1:0] RRV_MAX      = 2'd3;
   localparam logic [RRV_W-1:0] RRV_INIT     = 2'd2;
   localparam logic [RRV_W-1:0] RRV_NEAR     = 2'd0;

   localparam logic [SCNT_W-1:0] SCNT_INIT   = 2'd1;
   localparam logic [SCNT_W-1:0] SCNT_MAX    = 2'd3;
   localparam logic [SCNT_W-1:0] HOT_LEVEL   = 2'd2;

   localparam logic [STREAM_W-1:0] STREAM_SAT = 3'd4;
   localparam logic [STREAM_W-1:0] STREAM_ON  = 3'd3;

   typedef struct packed {
      logic [ADDR_W-1:0]   prev_address;
      logic [ADDR_W-1:0]   prev_stride;
      logic [STREAM_W-1:0] stream_count;
   } det_type;

   typedef struct packed {
      logic clear_step;
      logic capture;
      logic set_read;
      logic stage1;
      logic stage2;
      logic finish_upd;
      logic finish_vic;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_update;
   } status_type;

endpackage

// File: hdl/srsbr_if.sv
// ----------------------------------------------------------------------------
// srsbr_req_if / srsbr_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface srsbr_req_if;
   logic                           valid;
   logic                           ready;
   logic                           cmd;
   logic [srsbr_pkg::SET_IN_W-1:0] set_index;
   logic [srsbr_pkg::WAY_IN_W-1:0] way_index;
   logic [srsbr_pkg::ADDR_W-1:0]   address;
   logic [srsbr_pkg::PC_W-1:0]     pc;
   logic                           hit;

   modport source (output valid, cmd, set_index, way_index, address, pc, hit,
                   input ready);
   modport sink   (input valid, cmd, set_index, way_index, address, pc, hit,
                   output ready);
endinterface

interface srsbr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [srsbr_pkg::WAY_IN_W-1:0] victim_way;
   logic [srsbr_pkg::RRV_W-1:0]    new_priority;
   logic                           streaming;

   modport source (output valid, victim_way, new_priority, streaming, input ready);
   modport sink   (input valid, victim_way, new_priority, streaming, output ready);
endinterface

// File: hdl/srsbr_ctrl.sv
// ----------------------------------------------------------------------------
// srsbr_ctrl
// Sequencer: clearing pass, request capture and the per-command steps.
// ----------------------------------------------------------------------------
module srsbr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   input  srsbr_pkg::status_type status,
   output srsbr_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_VICTIM, S_STAGE1, S_STAGE2, S_STAGE3
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            cmd.set_read = 1'b1;
            state_in     = status.is_update ? S_STAGE1 : S_VICTIM;
         end
         S_VICTIM: begin
            if (out_free) begin
               cmd.finish_vic = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_STAGE1: begin
            cmd.stage1 = 1'b1;
            state_in   = S_STAGE2;
         end
         S_STAGE2: begin
            cmd.stage2 = 1'b1;
            state_in   = S_STAGE3;
         end
         S_STAGE3: begin
            if (out_free) begin
               cmd.finish_upd = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/srsbr_dp.sv
// ----------------------------------------------------------------------------
// srsbr_dp
// Per-set memories, signature counters, stride detector and victim search.
// ----------------------------------------------------------------------------
module srsbr_dp #(
   parameter int NUM_SETS = srsbr_pkg::NUM_SETS_DEF,
   parameter int NUM_WAYS = srsbr_pkg::NUM_WAYS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  srsbr_pkg::cmd_type               cmd,
   output srsbr_pkg::status_type            status,
   input  logic                             req_cmd,
   input  logic [srsbr_pkg::SET_IN_W-1:0]   req_set_index,
   input  logic [srsbr_pkg::WAY_IN_W-1:0]   req_way_index,
   input  logic [srsbr_pkg::ADDR_W-1:0]     req_address,
   input  logic [srsbr_pkg::PC_W-1:0]       req_pc,
   input  logic                             req_hit,
   output logic [srsbr_pkg::WAY_IN_W-1:0]   rsp_victim_way,
   output logic [srsbr_pkg::RRV_W-1:0]      rsp_new_priority,
   output logic                             rsp_streaming
);

   localparam int SET_W   = $clog2(NUM_SETS);
   localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int RROW_W  = NUM_WAYS * srsbr_pkg::RRV_W;
   localparam int SROW_W  = NUM_WAYS * srsbr_pkg::SIG_W;
   localparam int SIG_N   = 1 << srsbr_pkg::SIG_W;

   logic [RROW_W-1:0]             reref_mem [NUM_SETS];
   logic [SROW_W-1:0]             sig_mem   [NUM_SETS];
   srsbr_pkg::det_type            det_mem   [NUM_SETS];
   logic [srsbr_pkg::SCNT_W-1:0]  cnt_mem   [SIG_N];

   logic [SET_W-1:0]              clr_idx_ff;
   logic                          is_upd_ff;
   logic [SET_W-1:0]              set_ff;
   logic [WAY_W-1:0]              way_ff;
   logic [srsbr_pkg::ADDR_W-1:0]  addr_ff;
   logic                          hit_ff;
   logic [srsbr_pkg::SIG_W-1:0]   sig_ff;
   logic [RROW_W-1:0]             reref_rd_ff;
   logic [SROW_W-1:0]             sig_rd_ff;
   srsbr_pkg::det_type            det_rd_ff;
   logic [srsbr_pkg::SCNT_W-1:0]  cnt_rd_ff;
   logic [srsbr_pkg::SIG_W-1:0]   old_sig_ff;
   logic                          streaming_ff;
   logic [srsbr_pkg::SCNT_W-1:0]  cnt_new_ff;
   logic [srsbr_pkg::WAY_IN_W-1:0] victim_way_ff;
   logic [srsbr_pkg::RRV_W-1:0]   new_priority_ff;
   logic                          rsp_streaming_ff;

   logic [SET_W-1:0]              set_in;
   logic [srsbr_pkg::SIG_W-1:0]   sig_in;
   logic [srsbr_pkg::ADDR_W-1:0]  stride;
   srsbr_pkg::det_type            det_in;
   logic [srsbr_pkg::SIG_W-1:0]   old_sig;
   logic [srsbr_pkg::SCNT_W-1:0]  cnt_new_in;
   logic [srsbr_pkg::SCNT_W-1:0]  cnt_cur;
   logic                          hot;
   logic [srsbr_pkg::RRV_W-1:0]   prio;
   logic [RROW_W-1:0]             reref_upd;
   logic [SROW_W-1:0]             sig_upd;
   logic                          has3, has2, has1;
   logic [srsbr_pkg::RRV_W-1:0]   top;
   logic [srsbr_pkg::RRV_W-1:0]   age;
   logic [RROW_W-1:0]             reref_aged;
   logic [WAY_W-1:0]              first_way;

   assign status.clear_last = (clr_idx_ff == SET_W'(NUM_SETS - 1));
   assign status.is_update  = is_upd_ff;

   assign set_in = SET_W'(req_set_index);
   assign sig_in = req_pc[srsbr_pkg::SIG_W+1:2] ^ set_in[srsbr_pkg::SIG_W-1:0];

   // stride detector
   always_comb begin
      stride          = addr_ff - det_rd_ff.prev_address;
      det_in.prev_address = addr_ff;
      det_in.prev_stride  = stride;
      if (det_rd_ff.prev_stride != '0 && stride == det_rd_ff.prev_stride) begin
         if (det_rd_ff.stream_count < srsbr_pkg::STREAM_SAT)
            det_in.stream_count = det_rd_ff.stream_count + 3'd1;
         else
            det_in.stream_count = det_rd_ff.stream_count;
      end else begin
         det_in.stream_count = '0;
      end
   end

   assign old_sig = sig_rd_ff[way_ff*srsbr_pkg::SIG_W +: srsbr_pkg::SIG_W];

   // signature counter training
   always_comb begin
      if (hit_ff)
         cnt_new_in = (cnt_rd_ff < srsbr_pkg::SCNT_MAX) ? cnt_rd_ff + 2'd1 : cnt_rd_ff;
      else
         cnt_new_in = (cnt_rd_ff != '0) ? cnt_rd_ff - 2'd1 : cnt_rd_ff;
   end

   // insertion priority
   always_comb begin
      cnt_cur = (sig_ff == old_sig_ff) ? cnt_new_ff : cnt_rd_ff;
      hot     = (cnt_cur >= srsbr_pkg::HOT_LEVEL);
      if (hit_ff)
         prio = srsbr_pkg::RRV_NEAR;
      else if (streaming_ff)
         prio = hot ? srsbr_pkg::RRV_INIT : srsbr_pkg::RRV_MAX;
      else
         prio = hot ? srsbr_pkg::RRV_NEAR : srsbr_pkg::RRV_INIT;
      reref_upd = reref_rd_ff;
      reref_upd[way_ff*srsbr_pkg::RRV_W +: srsbr_pkg::RRV_W] = prio;
      sig_upd = sig_rd_ff;
      if (!hit_ff) sig_upd[way_ff*srsbr_pkg::SIG_W +: srsbr_pkg::SIG_W] = sig_ff;
   end

   // victim search: age the row so the largest value reaches the maximum
   always_comb begin
      has3 = 1'b0;
      has2 = 1'b0;
      has1 = 1'b0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         has3 |= (reref_rd_ff[w*2 +: 2] == 2'd3);
         has2 |= (reref_rd_ff[w*2 +: 2] == 2'd2);
         has1 |= (reref_rd_ff[w*2 +: 2] == 2'd1);
      end
      top = has3 ? 2'd3 : has2 ? 2'd2 : has1 ? 2'd1 : 2'd0;
      age = srsbr_pkg::RRV_MAX - top;
      for (int w = 0; w < NUM_WAYS; w++)
         reref_aged[w*2 +: 2] = reref_rd_ff[w*2 +: 2] + age;
      first_way = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--)
         if (reref_aged[w*2 +: 2] == srsbr_pkg::RRV_MAX) first_way = WAY_W'(w);
   end

   always_ff @(posedge clock) begin
      if (reset) clr_idx_ff <= '0;
      else if (cmd.clear_step) clr_idx_ff <= clr_idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         is_upd_ff <= (req_cmd == srsbr_pkg::CMD_UPDATE);
         set_ff    <= set_in;
         way_ff    <= WAY_W'(req_way_index);
         addr_ff   <= req_address;
         hit_ff    <= req_hit;
         sig_ff    <= sig_in;
      end
      if (cmd.stage1) begin
         old_sig_ff   <= old_sig;
         streaming_ff <= (det_in.stream_count >= srsbr_pkg::STREAM_ON);
      end
      if (cmd.stage2) cnt_new_ff <= cnt_new_in;
      if (cmd.finish_vic) begin
         victim_way_ff    <= srsbr_pkg::WAY_IN_W'(first_way);
         new_priority_ff  <= '0;
         rsp_streaming_ff <= 1'b0;
      end else if (cmd.finish_upd) begin
         victim_way_ff    <= '0;
         new_priority_ff  <= prio;
         rsp_streaming_ff <= streaming_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) reref_mem[clr_idx_ff] <= {NUM_WAYS{srsbr_pkg::RRV_INIT}};
      else if (cmd.finish_vic) reref_mem[set_ff] <= reref_aged;
      else if (cmd.finish_upd) reref_mem[set_ff] <= reref_upd;
      if (cmd.set_read) reref_rd_ff <= reref_mem[set_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) sig_mem[clr_idx_ff] <= '0;
      else if (cmd.finish_upd) sig_mem[set_ff] <= sig_upd;
      if (cmd.set_read) sig_rd_ff <= sig_mem[set_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) det_mem[clr_idx_ff] <= '0;
      else if (cmd.stage1) det_mem[set_ff] <= det_in;
      if (cmd.set_read) det_rd_ff <= det_mem[set_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) cnt_mem[clr_idx_ff[srsbr_pkg::SIG_W-1:0]] <= srsbr_pkg::SCNT_INIT;
      else if (cmd.stage2) cnt_mem[old_sig_ff] <= cnt_new_in;
      if (cmd.stage1) cnt_rd_ff <= cnt_mem[old_sig];
      else if (cmd.stage2) cnt_rd_ff <= cnt_mem[sig_ff];
   end

   assign rsp_victim_way   = victim_way_ff;
   assign rsp_new_priority = new_priority_ff;
   assign rsp_streaming    = rsp_streaming_ff;

endmodule

// File: hdl/signature_rrip_stream_bypass_replacement.sv
// ----------------------------------------------------------------------------
// signature_rrip_stream_bypass_replacement
// RRIP replacement engine with signature training and per-set stream detect.
//
// req_ch carries one request word: a victim query (cmd 0) or an update after
// an access (cmd 1). rsp_ch returns exactly one word per request, in order.
// A victim query reads the per-set memories and writes back the aged row; an
// update reads them, then reads, trains and rereads the signature counter
// table before its writeback.
// One request is in flight at a time; req_ch.ready is high only while the
// engine is idle.
// After reset a clearing pass steps through the sets and initializes every memory;
// no request is taken until it ends.
// The response register holds its word while rsp_ch.ready is low; the engine
// stalls before committing the next result until that word is taken.
// ----------------------------------------------------------------------------
module signature_rrip_stream_bypass_replacement #(
   parameter int NUM_SETS = srsbr_pkg::NUM_SETS_DEF,
   parameter int NUM_WAYS = srsbr_pkg::NUM_WAYS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   srsbr_req_if.sink    req_ch,
   srsbr_rsp_if.source  rsp_ch
);

   srsbr_pkg::cmd_type    cmd;
   srsbr_pkg::status_type status;

   srsbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .status    (status),
      .cmd       (cmd)
   );

   srsbr_dp #(
      .NUM_SETS (NUM_SETS),
      .NUM_WAYS (NUM_WAYS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_cmd          (req_ch.cmd),
      .req_set_index    (req_ch.set_index),
      .req_way_index    (req_ch.way_index),
      .req_address      (req_ch.address),
      .req_pc           (req_ch.pc),
      .req_hit          (req_ch.hit),
      .rsp_victim_way   (rsp_ch.victim_way),
      .rsp_new_priority (rsp_ch.new_priority),
      .rsp_streaming    (rsp_ch.streaming)
   );

endmodule

// File: hdl/srsbr_checker.sv
// ----------------------------------------------------------------------------
// srsbr_port_checks
// Port-level checks of the replacement engine, bound to the top level.
// ----------------------------------------------------------------------------
module srsbr_port_checks (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [srsbr_pkg::WAY_IN_W-1:0] victim_way,
   input logic [srsbr_pkg::RRV_W-1:0]    new_priority,
   input logic                           streaming
);

   a_reset_quiet : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(victim_way)
         && $stable(new_priority) && $stable(streaming)))
      else $error("stalled response word changed");

   a_victim_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && victim_way != '0) |-> (new_priority == '0 && !streaming))
      else $error("victim word carries update fields");

endmodule

bind signature_rrip_stream_bypass_replacement srsbr_port_checks u_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .victim_way   (rsp_ch.victim_way),
   .new_priority (rsp_ch.new_priority),
   .streaming    (rsp_ch.streaming)
);

// File: sim/srsbr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsbr_checker
// Watches both channels of the replacement engine, predicts each response
// word from accepted request words and compares field by field, in order.
// ----------------------------------------------------------------------------
module srsbr_checker (
   input  logic       clock,
   input  logic       reset,
   srsbr_req_if       req_ch,
   srsbr_rsp_if       rsp_ch,
   output int         fail_count,
   output int         pending,
   output int         victim_seen,
   output int         update_seen
);

   localparam int NSETS = srsbr_pkg::NUM_SETS_DEF;
   localparam int NWAYS = srsbr_pkg::NUM_WAYS_DEF;

   typedef struct {
      logic [srsbr_pkg::WAY_IN_W-1:0] victim_way;
      logic [srsbr_pkg::RRV_W-1:0]    new_priority;
      logic                           streaming;
   } rsp_word_type;

   logic [srsbr_pkg::RRV_W-1:0]    rrv_mem [NSETS*NWAYS];
   logic [srsbr_pkg::SIG_W-1:0]    sig_mem [NSETS*NWAYS];
   logic [srsbr_pkg::SCNT_W-1:0]   sig_cnt [64];
   logic [srsbr_pkg::ADDR_W-1:0]   last_addr [NSETS];
   logic [srsbr_pkg::ADDR_W-1:0]   last_stride [NSETS];
   logic [srsbr_pkg::STREAM_W-1:0] run_len [NSETS];
   rsp_word_type                   expected_rsp [$];

   task automatic clear_tables();
      foreach (rrv_mem[i]) begin
         rrv_mem[i] = srsbr_pkg::RRV_INIT;
         sig_mem[i] = '0;
      end
      foreach (sig_cnt[i]) sig_cnt[i] = srsbr_pkg::SCNT_INIT;
      foreach (last_addr[i]) begin
         last_addr[i] = '0;
         last_stride[i] = '0;
         run_len[i] = '0;
      end
   endtask

   function automatic rsp_word_type predict_replacement(logic c,
         logic [srsbr_pkg::SET_IN_W-1:0] s, logic [srsbr_pkg::WAY_IN_W-1:0] w,
         logic [srsbr_pkg::ADDR_W-1:0] a, logic [srsbr_pkg::PC_W-1:0] p, logic h);
      rsp_word_type r;
      int base;
      int line;
      logic [srsbr_pkg::RRV_W-1:0] top;
      logic [srsbr_pkg::ADDR_W-1:0] stride;
      logic [srsbr_pkg::SIG_W-1:0] sig;
      logic [srsbr_pkg::SIG_W-1:0] old_sig;
      logic found;
      r.victim_way = '0;
      r.new_priority = '0;
      r.streaming = 1'b0;
      base = int'(s) * NWAYS;
      line = base + int'(w);
      if (c == srsbr_pkg::CMD_VICTIM) begin
         top = '0;
         found = 1'b0;
         for (int i = 0; i < NWAYS; i++)
            if (rrv_mem[base+i] > top) top = rrv_mem[base+i];
         for (int i = 0; i < NWAYS; i++) begin
            rrv_mem[base+i] = rrv_mem[base+i] + (srsbr_pkg::RRV_MAX - top);
            if (!found && rrv_mem[base+i] == srsbr_pkg::RRV_MAX) begin
               r.victim_way = i[srsbr_pkg::WAY_IN_W-1:0];
               found = 1'b1;
            end
         end
         return r;
      end
      sig = p[srsbr_pkg::SIG_W+1:2] ^ s[srsbr_pkg::SIG_W-1:0];
      stride = a - last_addr[s];
      if (last_stride[s] != '0 && stride == last_stride[s]) begin
         if (run_len[s] < srsbr_pkg::STREAM_SAT) run_len[s]++;
      end else begin
         run_len[s] = '0;
      end
      last_stride[s] = stride;
      last_addr[s] = a;
      r.streaming = run_len[s] >= srsbr_pkg::STREAM_ON;
      old_sig = sig_mem[line];
      if (h) begin
         if (sig_cnt[old_sig] < srsbr_pkg::SCNT_MAX) sig_cnt[old_sig]++;
         r.new_priority = srsbr_pkg::RRV_NEAR;
      end else begin
         if (sig_cnt[old_sig] > 0) sig_cnt[old_sig]--;
         sig_mem[line] = sig;
         if (r.streaming)
            r.new_priority = (sig_cnt[sig] >= srsbr_pkg::HOT_LEVEL) ?
                             srsbr_pkg::RRV_INIT : srsbr_pkg::RRV_MAX;
         else
            r.new_priority = (sig_cnt[sig] >= srsbr_pkg::HOT_LEVEL) ?
                             srsbr_pkg::RRV_NEAR : srsbr_pkg::RRV_INIT;
      end
      rrv_mem[line] = r.new_priority;
      return r;
   endfunction

   initial clear_tables();

   assign pending = expected_rsp.size();

   always @(posedge clock) begin
      rsp_word_type e;
      if (reset) begin
         fail_count <= 0;
         victim_seen <= 0;
         update_seen <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp.size() == 0) begin
               $error("response word with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_ch.victim_way !== e.victim_way ||
                   rsp_ch.new_priority !== e.new_priority ||
                   rsp_ch.streaming !== e.streaming)
                  fail_count <= fail_count + 1;
               if (rsp_ch.victim_way !== e.victim_way)
                  $error("victim_way expected %0d actual %0d", e.victim_way, rsp_ch.victim_way);
               if (rsp_ch.new_priority !== e.new_priority)
                  $error("new_priority expected %0d actual %0d",
                         e.new_priority, rsp_ch.new_priority);
               if (rsp_ch.streaming !== e.streaming)
                  $error("streaming expected %0d actual %0d", e.streaming, rsp_ch.streaming);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_rsp.push_back(predict_replacement(req_ch.cmd, req_ch.set_index,
               req_ch.way_index, req_ch.address, req_ch.pc, req_ch.hit));
            if (req_ch.cmd == srsbr_pkg::CMD_VICTIM) victim_seen <= victim_seen + 1;
            else update_seen <= update_seen + 1;
         end
      end
   end

endmodule

// File: sim/tb_signature_rrip_stream_bypass_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signature_rrip_stream_bypass_replacement
// Drives victim and update words in bursts, including strided streams on a
// few hot sets, stalls the response side, and reports the checker verdict.
// ----------------------------------------------------------------------------
module tb_signature_rrip_stream_bypass_replacement;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   victim_seen;
   int   update_seen;
   int   sent;
   int   burst_left;
   logic [srsbr_pkg::ADDR_W-1:0] stream_addr [4];
   logic [srsbr_pkg::ADDR_W-1:0] stream_step [4];

   srsbr_req_if req_ch ();
   srsbr_rsp_if rsp_ch ();

   signature_rrip_stream_bypass_replacement uut (
      .clock (clock), .reset (reset), .req_ch (req_ch.sink), .rsp_ch (rsp_ch.source)
   );

   srsbr_checker checker_i (
      .clock (clock), .reset (reset), .req_ch (req_ch), .rsp_ch (rsp_ch),
      .fail_count (fail_count), .pending (pending),
      .victim_seen (victim_seen), .update_seen (update_seen)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.cmd = srsbr_pkg::CMD_VICTIM;
      req_ch.set_index = '0;
      req_ch.way_index = '0;
      req_ch.address = '0;
      req_ch.pc = '0;
      req_ch.hit = 1'b0;
      rsp_ch.ready = 1'b0;
   end

   // receiver: stall pattern with long free-running stretches
   always @(posedge clock) begin
      int phase;
      phase = $urandom_range(0, 99);
      if (reset) rsp_ch.ready <= 1'b0;
      else if (sent < 400) rsp_ch.ready <= (phase < 70);
      else if (sent < 800) rsp_ch.ready <= 1'b1;
      else rsp_ch.ready <= (phase < 40);
   end

   task automatic send_word(logic c, logic [srsbr_pkg::SET_IN_W-1:0] s,
                            logic [srsbr_pkg::WAY_IN_W-1:0] w,
                            logic [srsbr_pkg::ADDR_W-1:0] a,
                            logic [srsbr_pkg::PC_W-1:0] p, logic h);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.cmd <= c;
      req_ch.set_index <= s;
      req_ch.way_index <= w;
      req_ch.address <= a;
      req_ch.pc <= p;
      req_ch.hit <= h;
      do @(posedge clock); while (!req_ch.ready);
      sent++;
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 12);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic int j_hot(int unsigned r);
      return (r % 4) * 509 + 3;
   endfunction

   initial begin
      int k;
      int wait_cycles;
      logic [srsbr_pkg::SET_IN_W-1:0] s;
      sent = 0;
      burst_left = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, hits and misses, a stride run on set 5
      send_word(srsbr_pkg::CMD_VICTIM, '0, '0, '0, '0, 1'b0);
      send_word(srsbr_pkg::CMD_VICTIM, '1, '1, '1, '1, 1'b1);
      send_word(srsbr_pkg::CMD_UPDATE, '0, '0, '0, '0, 1'b0);
      send_word(srsbr_pkg::CMD_UPDATE, '1, '1, '1, '1, 1'b1);
      send_word(srsbr_pkg::CMD_UPDATE, '1, '1, '1, '1, 1'b0);
      for (int i = 0; i < 7; i++)
         send_word(srsbr_pkg::CMD_UPDATE, 11'd5, i[3:0],
                   64'hFFFF_FFFF_FFFF_FFC0 + 64'(i) * 64, 64'h40, 1'b0);
      for (int i = 0; i < 4; i++)
         send_word(srsbr_pkg::CMD_UPDATE, 11'd5, i[3:0],
                   64'hFFFF_FFFF_FFFF_FFC0 + 64'(i) * 64, 64'h40, 1'b1);
      for (int i = 0; i < 3; i++)
         send_word(srsbr_pkg::CMD_UPDATE, 11'd5, 4'(8 + i), 64'h100 + 64'(i) * 64,
                   64'h40, 1'b0);
      send_word(srsbr_pkg::CMD_VICTIM, 11'd5, '0, '0, '0, 1'b0);
      send_word(srsbr_pkg::CMD_VICTIM, 11'd5, '0, '0, '0, 1'b0);
      send_word(srsbr_pkg::CMD_VICTIM, '0, '0, '0, '0, 1'b0);
      for (int i = 0; i < 4; i++) begin
         stream_addr[i] = rand64();
         stream_step[i] = 64'($urandom_range(1, 8)) << 6;
      end
      // random: mostly strides and reuse on a few hot sets
      while (sent < 1500) begin
         k = $urandom_range(0, 99);
         if (k < 45) begin
            int j;
            j = $urandom_range(0, 3);
            stream_addr[j] += stream_step[j];
            send_word(srsbr_pkg::CMD_UPDATE, 11'(j * 509 + 3), 4'($urandom()),
                      stream_addr[j], 64'($urandom_range(0, 255)), 1'($urandom()));
         end else if (k < 70) begin
            s = 11'($urandom_range(0, 15));
            send_word(srsbr_pkg::CMD_UPDATE, s, 4'($urandom()), rand64(),
                      64'($urandom_range(0, 255)), 1'($urandom()));
         end else if (k < 85) begin
            s = ($urandom_range(0, 1)) ? 11'($urandom_range(0, 15)) : 11'(j_hot($urandom()));
            send_word(srsbr_pkg::CMD_VICTIM, s, 4'($urandom()), rand64(), rand64(),
                      1'($urandom()));
         end else begin
            send_word(1'($urandom()), 11'($urandom()), 4'($urandom()), rand64(), rand64(),
                      1'($urandom()));
         end
      end
      req_ch.valid <= 1'b0;
      wait_cycles = 0;
      while (pending != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      $display("Sent %0d request words: %0d victim queries, %0d updates checked.",
               sent, victim_seen, update_seen);
      if (fail_count == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
